### hw/rtl/mcrc_pkg.sv
// ----------------------------------------------------------------------------
// mcrc_pkg: shared types and constants for the multi-channel CRC-32 engine
// Item formats, command codes, controller/datapath handshake structs and the
// reflected CRC-32 byte fold.
// ----------------------------------------------------------------------------
package mcrc_pkg;

  localparam int CHANNELS_DEFAULT = 16;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // command codes
  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_PUSH    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] channel;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        was_active;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic execute;   // apply the latched item to its context
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_release;  // latched item produces a result
  } dp_status_t;

  // fold one byte into a running value, LSB first
  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

### hw/rtl/mcrc_datapath.sv
// ----------------------------------------------------------------------------
// mcrc_datapath: context store and CRC update
// Holds the latched item, the per-channel running values and the result
// register.
// ----------------------------------------------------------------------------
module mcrc_datapath #(
  parameter int CHANNELS = mcrc_pkg::CHANNELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mcrc_pkg::ctl_cmd_t   ctl,
  input  mcrc_pkg::in_item_t   item,
  output mcrc_pkg::dp_status_t status,
  output mcrc_pkg::out_item_t  result
);
  import mcrc_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  in_item_t    item_q;
  logic [31:0] running_crc [CHANNELS];

  logic [IDX_W-1:0] idx;
  logic             ch_ok;
  logic [31:0]      cur;
  logic [31:0]      folded;

  assign idx    = IDX_W'(item_q.channel);
  assign ch_ok  = (32'(item_q.channel) < 32'(CHANNELS));
  assign cur    = ch_ok ? running_crc[idx] : 32'd0;
  assign folded = fold_byte(cur, item_q.data_byte);

  assign status.is_release = (item_q.cmd == CMD_RELEASE);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        running_crc[k] <= 32'd0;
      end
    end else if (ctl.execute && ch_ok) begin
      case (item_q.cmd)
        CMD_INIT:    running_crc[idx] <= CRC_ONES;
        CMD_PUSH:    if (cur != 32'd0) running_crc[idx] <= folded;
        CMD_RELEASE: running_crc[idx] <= 32'd0;
        default:     ;
      endcase
    end
  end

  // result payload; strobe comes from the controller
  always_ff @(posedge clk) begin
    if (ctl.execute && status.is_release) begin
      result.crc_value  <= (cur != 32'd0) ? (cur ^ CRC_ONES) : 32'd0;
      result.was_active <= (cur != 32'd0);
    end
  end

endmodule

### hw/rtl/mcrc_ctrl.sv
// ----------------------------------------------------------------------------
// mcrc_ctrl: command sequencer
// Two-state machine: takes an item, then applies it and raises done for
// release commands.
// ----------------------------------------------------------------------------
module mcrc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mcrc_pkg::dp_status_t status,
  output mcrc_pkg::ctl_cmd_t   ctl,
  output logic                 busy,
  output logic                 done
);
  import mcrc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  assign busy        = (state == ST_EXEC);
  assign ctl.capture = (state == ST_IDLE) && start;
  assign ctl.execute = (state == ST_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) state <= ST_EXEC;
        end
        ST_EXEC: begin
          done  <= status.is_release;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/multi_channel_crc32_engine_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_crc32_engine_unit: multi-channel CRC-32 engine
// Keeps CHANNELS independent reflected CRC-32 contexts (poly 0xEDB88320).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item (cmd, channel, data_byte) and raise start.
//   The transfer happens at the clock edge where start is high and busy is
//   low. Commands: init loads the context with all ones, push folds one
//   byte into it, release reports the value XOR all ones and clears it.
//   A context holding zero is inactive: push leaves it alone, release
//   reports zero with was_active low. Channels at or above CHANNELS are
//   always inactive. Undefined command codes are dropped.
//   Output channel: a release yields one result on result, marked by done
//   for exactly one cycle. The receiver cannot stall; it must take it.
//   Sequence: each item passes a capture step and then an execute step
//   where the context read, byte fold and write-back happen. busy is high
//   during the execute step. done is registered and rises in the cycle
//   after execute, while the next item may already be accepted.
//   Reset (rst, synchronous): all contexts clear to zero (inactive), the
//   sequencer returns to idle and done drops.
// ----------------------------------------------------------------------------
module multi_channel_crc32_engine_unit #(
  parameter int CHANNELS = mcrc_pkg::CHANNELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mcrc_pkg::in_item_t  item,
  output logic                done,
  output mcrc_pkg::out_item_t result
);
  import mcrc_pkg::*;

  // controller/datapath link
  ctl_cmd_t   ctl;
  dp_status_t status;

  // sequencer: accept, execute, result strobe
  mcrc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done)
  );

  // context store, CRC fold and result register
  mcrc_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .status (status),
    .result (result)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_channel_crc32_engine_unit
// A directed table runs first. It covers idle channels, single-byte CRCs, the
// unused command code and a running value that folds down to zero. Random
// command streams follow, with bursty sender pacing. Each release result is
// checked field by field against a fixed row or a cycle-free CRC context predictor.
// ----------------------------------------------------------------------------
module testbench;
  import mcrc_pkg::*;

  localparam int NUM_CH = CHANNELS_DEFAULT;

  // the one 2-bit code the engine must drop
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_TARGET  = 1550;  // at least this many items sent, directed rows included
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer at all
  localparam int SETTLE_CYCLES  = 8;     // tail after the last result
  localparam int REPORT_LIMIT   = 10;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  in_item_t  item;
  out_item_t result;

  // one row of the directed table; fixed rows carry a hand-derived result
  typedef struct {
    in_item_t  cmd_item;
    bit        echo_low;   // push the context's current low byte instead
    bit        fixed;
    out_item_t fixed_res;
  } step_row_t;

  step_row_t   directed_steps[$];
  logic [31:0] ctx_crc[NUM_CH];   // predicted running value per channel
  out_item_t   release_q[$];      // predicted release reports, oldest first
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          counted = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  multi_channel_crc32_engine_unit #(
    .CHANNELS(NUM_CH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Reflected CRC-32 byte step, one input bit per shift: the feedback bit is
  // the outgoing LSB xor the data bit, and it gates the polynomial.
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    logic        fb;
    v = crc;
    for (int i = 0; i < 8; i++) begin
      fb = v[0] ^ b[i];
      v  = {1'b0, v[31:1]} ^ (fb ? CRC_POLY : 32'h0);
    end
    return v;
  endfunction

  // Applies one command to the context table. Returns 1 when the command
  // reports (release only). A zero context is inactive: push skips it, and
  // release reports zero with the active flag low.
  function automatic bit apply_to_context(input in_item_t it, output out_item_t res);
    logic [31:0] cur;
    bit          in_range;
    in_range = int'(it.channel) < NUM_CH;
    cur      = in_range ? ctx_crc[it.channel] : 32'h0;
    res      = '0;
    case (it.cmd)
      CMD_INIT: begin
        if (in_range) ctx_crc[it.channel] = CRC_ONES;
        return 1'b0;
      end
      CMD_PUSH: begin
        if (in_range && cur != 32'h0) ctx_crc[it.channel] = crc_fold(cur, it.data_byte);
        return 1'b0;
      end
      CMD_RELEASE: begin
        if (cur != 32'h0) begin
          ctx_crc[it.channel] = 32'h0;
          res.crc_value  = cur ^ CRC_ONES;
          res.was_active = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Bursts of back-to-back transfers separated by random gaps. Now and then
  // a long burst keeps start high across many items.
  task automatic pace();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // Drives one item until the engine takes it, then predicts its effect.
  // The prediction runs at the edge of the transfer, so an echo byte picked
  // for the next item already sees this item's update.
  task automatic transfer(input in_item_t it, input bit echo, input bit fixed,
                          input out_item_t want);
    out_item_t predicted;
    if (echo) it.data_byte = ctx_crc[it.channel][7:0];
    pace();
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer took place at this edge
    if (apply_to_context(it, predicted)) release_q.push_back(fixed ? want : predicted);
    counted++;
  endtask

  // Holds off the sender until every predicted report has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (release_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_step(input logic [1:0] cmd, input logic [3:0] ch,
                          input logic [7:0] data, input bit echo, input bit fixed,
                          input logic [31:0] crc, input logic act);
    step_row_t row;
    row.cmd_item.cmd       = cmd;
    row.cmd_item.channel   = ch;
    row.cmd_item.data_byte = data;
    row.echo_low           = echo;
    row.fixed              = fixed;
    row.fixed_res.crc_value  = crc;
    row.fixed_res.was_active = act;
    directed_steps.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Result checker and activity counter
  // --------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatch_count < REPORT_LIMIT)
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // done lasts exactly one cycle and cannot be held off, so each strobe is
  // a result transfer at this edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (release_q.size() == 0) begin
          note_mismatch("unexpected result, crc_value", 32'h0, result.crc_value);
        end else begin
          want = release_q.pop_front();
          if (result.crc_value !== want.crc_value)
            note_mismatch("crc_value", want.crc_value, result.crc_value);
          if (result.was_active !== want.was_active)
            note_mismatch("was_active", 32'(want.was_active), 32'(result.was_active));
        end
      end
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  // watchdog: too long without a transfer in either direction
  initial begin
    @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int        r;
    logic [3:0] ch;
    in_item_t  it;
    out_item_t none;
    none = '0;
    foreach (ctx_crc[k]) ctx_crc[k] = 32'h0;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;

    // Directed table. Known values: CRC-32 of the single bytes 0x00, 0xFF
    // and 'a'. A zero-to-zero release still counts as active right after init.
    add_step(CMD_RELEASE, 4'd0,  8'h00, 0, 1, 32'h0,         1'b0); // idle after reset
    add_step(CMD_PUSH,    4'd1,  8'hAB, 0, 0, 32'h0,         1'b0); // push on idle channel
    add_step(CMD_RELEASE, 4'd1,  8'h00, 0, 1, 32'h0,         1'b0);
    add_step(CMD_INIT,    4'd15, 8'hFF, 0, 0, 32'h0,         1'b0);
    add_step(CMD_RELEASE, 4'd15, 8'h00, 0, 1, 32'h0,         1'b1); // empty message
    add_step(CMD_INIT,    4'd0,  8'h00, 0, 0, 32'h0,         1'b0);
    add_step(CMD_PUSH,    4'd0,  8'h00, 0, 0, 32'h0,         1'b0);
    add_step(CMD_RELEASE, 4'd0,  8'h00, 0, 1, 32'hD202_EF8D, 1'b1);
    add_step(CMD_INIT,    4'd9,  8'h00, 0, 0, 32'h0,         1'b0);
    add_step(CMD_PUSH,    4'd9,  8'hFF, 0, 0, 32'h0,         1'b0);
    add_step(CMD_RELEASE, 4'd9,  8'h00, 0, 1, 32'hFF00_0000, 1'b1);
    // two interleaved contexts, with a dropped code in between
    add_step(CMD_INIT,    4'd7,  8'h00, 0, 0, 32'h0,         1'b0);
    add_step(CMD_INIT,    4'd8,  8'h00, 0, 0, 32'h0,         1'b0);
    add_step(CMD_PUSH,    4'd7,  8'h61, 0, 0, 32'h0,         1'b0);
    add_step(CMD_PUSH,    4'd8,  8'h55, 0, 0, 32'h0,         1'b0);
    add_step(CMD_UNUSED,  4'd7,  8'h61, 0, 0, 32'h0,         1'b0);
    add_step(CMD_RELEASE, 4'd7,  8'h00, 0, 1, 32'hE8B7_BE43, 1'b1);
    add_step(CMD_RELEASE, 4'd8,  8'h00, 0, 0, 32'h0,         1'b0);
    // Pushing the current low byte shifts the value right by 8, so four such
    // pushes drive it to zero. The channel then sticks, even on later pushes.
    add_step(CMD_INIT,    4'd3,  8'h00, 0, 0, 32'h0,         1'b0);
    repeat (4) add_step(CMD_PUSH, 4'd3, 8'h00, 1, 0, 32'h0,   1'b0);
    add_step(CMD_PUSH,    4'd3,  8'h12, 0, 0, 32'h0,         1'b0);
    add_step(CMD_RELEASE, 4'd3,  8'h00, 0, 1, 32'h0,         1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[k])
      transfer(directed_steps[k].cmd_item, directed_steps[k].echo_low,
               directed_steps[k].fixed, directed_steps[k].fixed_res);
    drain();

    // Random part. Most traffic goes to four hot channels so that long
    // messages build up. The rest spreads over all channels.
    while (counted < RANDOM_TARGET) begin
      r  = $urandom_range(0, 99);
      ch = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                       : 4'($urandom_range(0, NUM_CH - 1));
      it.channel   = ch;
      it.data_byte = 8'($urandom_range(0, 255));
      if (r < 4) begin
        // fold a live channel down to zero, maybe poke it, then release it
        if (ctx_crc[ch] == 32'h0) begin
          it.cmd = CMD_INIT;
          transfer(it, 0, 0, none);
        end
        it.cmd = CMD_PUSH;
        repeat (4) transfer(it, 1, 0, none);
        if ($urandom_range(0, 1) != 0) transfer(it, 0, 0, none);
        it.cmd = CMD_RELEASE;
        transfer(it, 0, 0, none);
      end else begin
        if (r < 14)      it.cmd = CMD_INIT;
        else if (r < 76) it.cmd = CMD_PUSH;
        else if (r < 90) it.cmd = CMD_RELEASE;
        else if (r < 94) it.cmd = CMD_UNUSED;
        else             it.cmd = CMD_PUSH;   // low-byte echo push
        transfer(it, r >= 94, 0, none);
      end
      if ($urandom_range(0, 299) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && release_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mcrc_pkg.sv
hw/rtl/mcrc_datapath.sv
hw/rtl/mcrc_ctrl.sv
hw/rtl/multi_channel_crc32_engine_unit.sv
verif/testbench.sv
